[hw/rtl/polygon_area_perimeter_top_macros.svh]
// ----------------------------------------------------------------------------
// polygon_area_perimeter_top_macros.svh
// Assertion macros of the polygon area/perimeter checker.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_PERIMETER_TOP_MACROS_SVH
`define POLYGON_AREA_PERIMETER_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PAP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define PAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pap_pkg.sv]
// ----------------------------------------------------------------------------
// pap_pkg
// Shared constants and types of the polygon area/perimeter block.
// ----------------------------------------------------------------------------
`default_nettype none

package pap_pkg;

    localparam int COORD_BITS_DEF = 24;

    localparam int CROSS_SUM_BITS = 60;
    localparam int LEN_SUM_BITS   = 36;
    localparam int AREA_BITS      = 58;
    localparam int PERIM_BITS     = 35;

    // sequencer states of the serial units
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // handoff control between the edge units
    typedef struct packed {
        logic valid;
        logic last;
    } t_edge_ctl;

endpackage

`default_nettype wire

[hw/rtl/pap_if.sv]
// ----------------------------------------------------------------------------
// pap_if
// Valid/ready channels for vertex items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pap_vert_if import pap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic                         final_vertex;

    modport source (output valid, vert_x, vert_y, final_vertex, input ready);
    modport sink   (input valid, vert_x, vert_y, final_vertex, output ready);
endinterface

interface pap_res_if import pap_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [AREA_BITS-1:0]  twice_area;
    logic [PERIM_BITS-1:0] perimeter;

    modport source (output valid, twice_area, perimeter, input ready);
    modport sink   (input valid, twice_area, perimeter, output ready);
endinterface

`default_nettype wire

[hw/rtl/pap_mul.sv]
// ----------------------------------------------------------------------------
// pap_mul
// Bit-serial shift-add unit: shoelace cross term and squared edge length.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_mul import pap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_last,
    input  logic signed [COORD_BITS-1:0]  i_ax,
    input  logic signed [COORD_BITS-1:0]  i_ay,
    input  logic signed [COORD_BITS-1:0]  i_bx,
    input  logic signed [COORD_BITS-1:0]  i_by,
    output logic                          o_idle,
    output t_edge_ctl                     o_ctl,
    input  logic                          i_ready,
    output logic signed [2*COORD_BITS+1:0] o_cross,
    output logic [2*COORD_BITS+1:0]       o_sq
);

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * W + 2;
    localparam int CW = $clog2(W + 1);

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_last;
    logic signed [PW-1:0] r_mc_ax, r_mc_ay;
    logic [PW-1:0]        r_mc_dx, r_mc_dy;
    logic [W:0]           r_mp_by, r_mp_bx, r_mp_dx, r_mp_dy;
    logic signed [PW-1:0] r_acc_c;
    logic [PW-1:0]        r_acc_s;

    logic signed [W:0]    dx, dy;
    logic [W:0]           adx, ady;
    logic signed [PW-1:0] pp_c;
    logic                 last_step;

    always_comb begin
        dx  = {i_ax[W-1], i_ax} - {i_bx[W-1], i_bx};
        dy  = {i_ay[W-1], i_ay} - {i_by[W-1], i_by};
        adx = dx[W] ? (W+1)'(-dx) : dx;
        ady = dy[W] ? (W+1)'(-dy) : dy;
    end

    // ax*by - ay*bx, one multiplier bit per cycle
    assign pp_c      = (r_mp_by[0] ? r_mc_ax : '0) - (r_mp_bx[0] ? r_mc_ay : '0);
    assign last_step = (r_cnt == CW'(W));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_last  <= i_last;
            r_mc_ax <= {{(PW-W){i_ax[W-1]}}, i_ax};
            r_mc_ay <= {{(PW-W){i_ay[W-1]}}, i_ay};
            r_mc_dx <= {{(PW-W-1){1'b0}}, adx};
            r_mc_dy <= {{(PW-W-1){1'b0}}, ady};
            r_mp_by <= {i_by[W-1], i_by};
            r_mp_bx <= {i_bx[W-1], i_bx};
            r_mp_dx <= adx;
            r_mp_dy <= ady;
            r_acc_c <= '0;
            r_acc_s <= '0;
        end else if (r_state == ST_RUN) begin
            // top multiplier bit is the sign weight
            r_acc_c <= last_step ? r_acc_c - pp_c : r_acc_c + pp_c;
            r_acc_s <= r_acc_s + (r_mp_dx[0] ? r_mc_dx : '0)
                               + (r_mp_dy[0] ? r_mc_dy : '0);
            r_mc_ax <= r_mc_ax <<< 1;
            r_mc_ay <= r_mc_ay <<< 1;
            r_mc_dx <= r_mc_dx << 1;
            r_mc_dy <= r_mc_dy << 1;
            r_mp_by <= r_mp_by >> 1;
            r_mp_bx <= r_mp_bx >> 1;
            r_mp_dx <= r_mp_dx >> 1;
            r_mp_dy <= r_mp_dy >> 1;
        end
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_ctl.valid = (r_state == ST_DONE);
    assign o_ctl.last  = r_last;
    assign o_cross     = r_acc_c;
    assign o_sq        = r_acc_s;

endmodule

`default_nettype wire

[hw/rtl/pap_sqrt.sv]
// ----------------------------------------------------------------------------
// pap_sqrt
// Bit-per-cycle restoring integer square root of the squared edge length.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_sqrt import pap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_edge_ctl                      i_ctl,
    input  logic signed [2*COORD_BITS+1:0] i_cross,
    input  logic [2*COORD_BITS+1:0]        i_sq,
    output logic                           o_ready,
    output t_edge_ctl                      o_ctl,
    input  logic                           i_ready,
    output logic signed [2*COORD_BITS+1:0] o_cross,
    output logic [COORD_BITS:0]            o_root
);

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * W + 2;
    localparam int CW = $clog2(W + 1);

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_last;
    logic signed [PW-1:0] r_cross;
    logic [PW-1:0]        r_rad;
    logic [W+2:0]         r_rem;
    logic [W:0]           r_root;

    logic [W+4:0]         rem_sh, trial, diff;
    logic                 ge;
    logic                 last_step;

    // two radicand bits per step, one root bit out
    always_comb begin
        rem_sh = {r_rem, r_rad[PW-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
    end

    assign last_step = (r_cnt == CW'(W));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_ctl.valid) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.valid) begin
            r_last  <= i_ctl.last;
            r_cross <= i_cross;
            r_rad   <= i_sq;
            r_rem   <= '0;
            r_root  <= '0;
        end else if (r_state == ST_RUN) begin
            r_rem  <= ge ? diff[W+2:0] : rem_sh[W+2:0];
            r_root <= {r_root[W-1:0], ge};
            r_rad  <= r_rad << 2;
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_ctl.valid = (r_state == ST_DONE);
    assign o_ctl.last  = r_last;
    assign o_cross     = r_cross;
    assign o_root      = r_root;

endmodule

`default_nettype wire

[hw/rtl/pap_acc.sv]
// ----------------------------------------------------------------------------
// pap_acc
// Saturating area and perimeter sums, result register for closed polygons.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_acc import pap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_edge_ctl                      i_ctl,
    input  logic signed [2*COORD_BITS+1:0] i_cross,
    input  logic [COORD_BITS:0]            i_root,
    output logic                           o_ready,
    output logic                           o_valid,
    input  logic                           i_out_ready,
    output logic [AREA_BITS-1:0]           o_area,
    output logic [PERIM_BITS-1:0]          o_perim
);

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * W + 2;
    localparam int CS = CROSS_SUM_BITS;
    localparam int LS = LEN_SUM_BITS;

    logic signed [CS-1:0]  r_cross, n_cross;
    logic [LS-1:0]         r_len, n_len;
    logic                  r_emit;
    logic                  r_out_valid;
    logic [AREA_BITS-1:0]  r_area;
    logic [PERIM_BITS-1:0] r_perim;

    logic                  take;
    logic signed [CS:0]    sum_c;
    logic [LS:0]           sum_l;
    logic [CS-1:0]         abs_c;

    // a closing edge waits for the result register to drain
    assign o_ready = !r_emit && !(i_ctl.last && r_out_valid);
    assign take    = i_ctl.valid && o_ready;

    always_comb begin
        sum_c = {r_cross[CS-1], r_cross} + {{(CS+1-PW){i_cross[PW-1]}}, i_cross};
        sum_l = {1'b0, r_len} + {{(LS-W){1'b0}}, i_root};
        if (sum_c[CS] != sum_c[CS-1]) begin
            n_cross = sum_c[CS] ? {1'b1, {(CS-1){1'b0}}} : {1'b0, {(CS-1){1'b1}}};
        end else begin
            n_cross = sum_c[CS-1:0];
        end
        n_len = sum_l[LS] ? {LS{1'b1}} : sum_l[LS-1:0];
        abs_c = r_cross[CS-1] ? CS'(-r_cross) : r_cross;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross     <= '0;
            r_len       <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_emit) begin
                r_cross     <= '0;
                r_len       <= '0;
                r_emit      <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (take) begin
                    r_cross <= n_cross;
                    r_len   <= n_len;
                    r_emit  <= i_ctl.last;
                end
                if (r_out_valid && i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emit) begin
            r_area  <= (abs_c[CS-1:AREA_BITS] != '0) ? {AREA_BITS{1'b1}}
                                                     : abs_c[AREA_BITS-1:0];
            r_perim <= (r_len[LS-1:PERIM_BITS] != '0) ? {PERIM_BITS{1'b1}}
                                                      : r_len[PERIM_BITS-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_area  = r_area;
    assign o_perim = r_perim;

endmodule

`default_nettype wire

[hw/rtl/polygon_area_perimeter_top.sv]
// ----------------------------------------------------------------------------
// polygon_area_perimeter_top
// Streamed polygon: twice the shoelace area and the sum of floored edge lengths.
// Each edge runs a shift-add unit of COORD_BITS+1 steps, then a bit-per-cycle
// square root of COORD_BITS+1 steps; the two units overlap across edges.
// A vertex is taken when the shift-add unit is idle and no close is pending.
// A final vertex adds the closing edge, run through shift-add, root and sums
// into the result register. Synchronous active-low reset clears sums.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_perimeter_top import pap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pap_vert_if.sink  i_vert,
    pap_res_if.source o_res
);

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * W + 2;

    logic                r_have_first;
    logic                r_pend_close;
    logic signed [W-1:0] r_first_x, r_first_y;
    logic signed [W-1:0] r_prev_x, r_prev_y;

    logic                in_take;
    logic                close_go;
    logic                mul_start, mul_last, mul_idle;
    logic signed [W-1:0] ax, ay, bx, by;

    t_edge_ctl           mul_ctl, sq_ctl;
    logic                sq_ready, acc_ready;
    logic signed [PW-1:0] mul_cross, sq_cross;
    logic [PW-1:0]       mul_sq;
    logic [W:0]          sq_root;

    assign i_vert.ready = mul_idle && !r_pend_close;
    assign in_take      = i_vert.valid && i_vert.ready;
    assign close_go     = r_pend_close && mul_idle;

    // edge launch: previous->current on a later vertex, current->first on close
    always_comb begin
        mul_start = 1'b0;
        mul_last  = 1'b0;
        ax        = r_prev_x;
        ay        = r_prev_y;
        bx        = i_vert.vert_x;
        by        = i_vert.vert_y;
        if (in_take) begin
            if (r_have_first) begin
                mul_start = 1'b1;
            end else if (i_vert.final_vertex) begin
                // lone vertex closes onto itself
                mul_start = 1'b1;
                mul_last  = 1'b1;
                ax        = i_vert.vert_x;
                ay        = i_vert.vert_y;
            end
        end else if (close_go) begin
            mul_start = 1'b1;
            mul_last  = 1'b1;
            bx        = r_first_x;
            by        = r_first_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_pend_close <= 1'b0;
        end else if (in_take) begin
            r_have_first <= !i_vert.final_vertex;
            r_pend_close <= r_have_first && i_vert.final_vertex;
        end else if (close_go) begin
            r_pend_close <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_prev_x <= i_vert.vert_x;
            r_prev_y <= i_vert.vert_y;
            if (!r_have_first) begin
                r_first_x <= i_vert.vert_x;
                r_first_y <= i_vert.vert_y;
            end
        end
    end

    pap_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_last  (mul_last),
        .i_ax    (ax),
        .i_ay    (ay),
        .i_bx    (bx),
        .i_by    (by),
        .o_idle  (mul_idle),
        .o_ctl   (mul_ctl),
        .i_ready (sq_ready),
        .o_cross (mul_cross),
        .o_sq    (mul_sq)
    );

    pap_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_cross (mul_cross),
        .i_sq    (mul_sq),
        .o_ready (sq_ready),
        .o_ctl   (sq_ctl),
        .i_ready (acc_ready),
        .o_cross (sq_cross),
        .o_root  (sq_root)
    );

    pap_acc #(
        .COORD_BITS (COORD_BITS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sq_ctl),
        .i_cross     (sq_cross),
        .i_root      (sq_root),
        .o_ready     (acc_ready),
        .o_valid     (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_area      (o_res.twice_area),
        .o_perim     (o_res.perimeter)
    );

endmodule

`default_nettype wire

[hw/rtl/pap_checker.sv]
// ----------------------------------------------------------------------------
// pap_checker
// Port-level checks of the polygon area/perimeter block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_area_perimeter_top_macros.svh"

module pap_checker import pap_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_in_final,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [AREA_BITS-1:0]  i_area,
    input logic [PERIM_BITS-1:0] i_perim
);

    // stalled result holds
    `PAP_ASSERT_IMPL(a_out_hold, i_out_valid && !i_out_ready, ##1 (i_out_valid && $stable(i_area) && $stable(i_perim)), "stalled result changed")

    // result register is never refilled on the edge it drains
    `PAP_ASSERT_NEXT(a_out_gap, i_out_valid && i_out_ready, !i_out_valid, "result reloaded back to back")

    // a final vertex always starts edge work, so the input closes
    `PAP_ASSERT_NEXT(a_final_busy, i_in_valid && i_in_ready && i_in_final, !i_in_ready, "input open after final vertex")

endmodule

bind polygon_area_perimeter_top pap_checker u_pap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vert.valid),
    .i_in_ready  (i_vert.ready),
    .i_in_final  (i_vert.final_vertex),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_area      (o_res.twice_area),
    .i_perim     (o_res.perimeter)
);

`default_nettype wire
